// ----- rtl/bgc_pkg.sv -----
package bgc_pkg;

    // Default number of buttons held in the state memory.
    localparam int BUTTON_COUNT_DEF = 8;

    // Width of a tick threshold and of a per-button tick counter.
    localparam int TICK_W = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEBOUNCE        = 2'd0;
    localparam logic [1:0] CFG_LONG_PRESS      = 2'd1;
    localparam logic [1:0] CFG_LONG_LONG_PRESS = 2'd2;
    localparam logic [1:0] CFG_DCLICK_GAP      = 2'd3;

    // Per-button gesture state codes. Codes beyond the last member fall back to idle.
    typedef enum logic [3:0] {
        ST_IDLE               = 4'd0,
        ST_FIRST_PRESS        = 4'd1,
        ST_FIRST_VALID        = 4'd2,
        ST_FIRST_RELEASE      = 4'd3,
        ST_SECOND_PRESS       = 4'd4,
        ST_SECOND_VALID       = 4'd5,
        ST_LONG_PRESS         = 4'd6,
        ST_LONG_RELEASE       = 4'd7,
        ST_SHORT_LONG_PRESS   = 4'd8,
        ST_SHORT_LONG_RELEASE = 4'd9,
        ST_LL_PRESS           = 4'd10,
        ST_LL_RELEASE         = 4'd11
    } gesture_state_t;

    // Event codes reported with each scan tick.
    typedef enum logic [3:0] {
        EV_NONE           = 4'd0,
        EV_SINGLE         = 4'd1,
        EV_DOUBLE         = 4'd2,
        EV_LONG           = 4'd3,
        EV_LONG_REL       = 4'd4,
        EV_SHORT_LONG     = 4'd5,
        EV_SHORT_LONG_REL = 4'd6,
        EV_LL             = 4'd7,
        EV_LL_REL         = 4'd8
    } event_code_t;

    // One entry of the per-button state memory.
    typedef struct packed {
        gesture_state_t     state;
        logic [TICK_W-1:0]  count;
    } btn_entry_t;

    // The four tick thresholds.
    typedef struct packed {
        logic [TICK_W-1:0] debounce;
        logic [TICK_W-1:0] long_press;
        logic [TICK_W-1:0] long_long_press;
        logic [TICK_W-1:0] dclick_gap;
    } thresholds_t;

    localparam btn_entry_t ENTRY_RESET = '{state: ST_IDLE, count: '0};

    localparam thresholds_t THR_RESET = '{
        debounce:        16'd2,
        long_press:      16'd100,
        long_long_press: 16'd300,
        dclick_gap:      16'd30
    };

    // Difference a - b, clamped at zero.
    function automatic logic [TICK_W-1:0] sat_diff(input logic [TICK_W-1:0] a,
                                                   input logic [TICK_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

// ----- rtl/bgc_state_mem.sv -----
module bgc_state_mem #(
    parameter int DEPTH  = bgc_pkg::BUTTON_COUNT_DEF,
    parameter int ADDR_W = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output bgc_pkg::btn_entry_t rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  bgc_pkg::btn_entry_t wr_data
);

    bgc_pkg::btn_entry_t mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    bgc_pkg::btn_entry_t mem_q_reg;
    bgc_pkg::btn_entry_t fwd_q_reg;
    logic                hit_q_reg;
    logic                fwd_sel_reg;

    // Storage array with a registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
            fwd_q_reg <= wr_data;
        end
    end

    // Per-entry valid bits and the bypass select for a read that meets a write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            hit_q_reg   <= 1'b0;
            fwd_sel_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                hit_q_reg   <= valid_reg[rd_addr];
                fwd_sel_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // An entry never written since reset reads as idle with a zero counter.
    assign rd_data = fwd_sel_reg ? fwd_q_reg :
                     (hit_q_reg ? mem_q_reg : bgc_pkg::ENTRY_RESET);

endmodule

// ----- rtl/bgc_gesture_step.sv -----
module bgc_gesture_step (
    input  bgc_pkg::btn_entry_t  cur,
    input  logic                 pressed,
    input  bgc_pkg::thresholds_t thr,
    output bgc_pkg::btn_entry_t  nxt,
    output bgc_pkg::event_code_t ev
);

    logic [bgc_pkg::TICK_W-1:0] valid_span;
    logic [bgc_pkg::TICK_W-1:0] ll_span;
    logic [bgc_pkg::TICK_W-1:0] limit;
    logic [bgc_pkg::TICK_W:0]   inc;
    logic                       reach;
    logic [bgc_pkg::TICK_W-1:0] stepped;
    logic                       past_deb;
    logic                       below_gap;

    // Stage lengths between thresholds, clamped when thresholds are out of order.
    assign valid_span = bgc_pkg::sat_diff(thr.long_press, thr.debounce);
    assign ll_span    = bgc_pkg::sat_diff(thr.long_long_press, thr.long_press);

    // Pick the limit that the current state counts toward.
    always_comb begin
        case (cur.state)
            bgc_pkg::ST_FIRST_PRESS,
            bgc_pkg::ST_SECOND_PRESS:  limit = thr.debounce;
            bgc_pkg::ST_FIRST_VALID,
            bgc_pkg::ST_SECOND_VALID:  limit = valid_span;
            bgc_pkg::ST_LONG_PRESS:    limit = ll_span;
            default:                   limit = thr.dclick_gap;
        endcase
    end

    // Shared counter increment; a reached limit clears the counter.
    assign inc     = {1'b0, cur.count} + 17'd1;
    assign reach   = (inc >= {1'b0, limit});
    assign stepped = reach ? '0 : inc[bgc_pkg::TICK_W-1:0];

    assign past_deb  = (cur.count >= thr.debounce);
    assign below_gap = (cur.count < thr.dclick_gap);

    // Gesture transitions.
    always_comb begin
        nxt = cur;
        ev  = bgc_pkg::EV_NONE;
        unique case (cur.state)
            bgc_pkg::ST_IDLE: begin
                nxt.count = '0;
                nxt.state = pressed ? bgc_pkg::ST_FIRST_PRESS : bgc_pkg::ST_IDLE;
            end
            bgc_pkg::ST_FIRST_PRESS: begin
                if (pressed) begin
                    nxt.count = stepped;
                    if (reach) begin
                        nxt.state = bgc_pkg::ST_FIRST_VALID;
                    end
                end else begin
                    nxt = bgc_pkg::ENTRY_RESET;
                end
            end
            bgc_pkg::ST_FIRST_VALID: begin
                if (pressed) begin
                    nxt.count = stepped;
                    if (reach) begin
                        nxt.state = bgc_pkg::ST_LONG_PRESS;
                        ev        = bgc_pkg::EV_LONG;
                    end
                end else begin
                    nxt.count = '0;
                    nxt.state = bgc_pkg::ST_FIRST_RELEASE;
                end
            end
            bgc_pkg::ST_FIRST_RELEASE: begin
                if (!pressed) begin
                    nxt.count = stepped;
                    if (reach) begin
                        nxt.state = bgc_pkg::ST_IDLE;
                        ev        = bgc_pkg::EV_SINGLE;
                    end
                end else if (past_deb && below_gap) begin
                    nxt.count = '0;
                    nxt.state = bgc_pkg::ST_SECOND_PRESS;
                end else if (!past_deb) begin
                    // A second press that comes too early ends the gesture.
                    nxt = bgc_pkg::ENTRY_RESET;
                    ev  = bgc_pkg::EV_SINGLE;
                end
            end
            bgc_pkg::ST_SECOND_PRESS: begin
                if (pressed) begin
                    nxt.count = stepped;
                    if (reach) begin
                        nxt.state = bgc_pkg::ST_SECOND_VALID;
                    end
                end else begin
                    nxt = bgc_pkg::ENTRY_RESET;
                    ev  = bgc_pkg::EV_SINGLE;
                end
            end
            bgc_pkg::ST_SECOND_VALID: begin
                if (pressed) begin
                    nxt.count = stepped;
                    if (reach) begin
                        nxt.state = bgc_pkg::ST_SHORT_LONG_PRESS;
                        ev        = bgc_pkg::EV_SHORT_LONG;
                    end
                end else begin
                    nxt = bgc_pkg::ENTRY_RESET;
                    ev  = bgc_pkg::EV_DOUBLE;
                end
            end
            bgc_pkg::ST_LONG_PRESS: begin
                if (pressed) begin
                    nxt.count = stepped;
                    if (reach) begin
                        nxt.state = bgc_pkg::ST_LL_PRESS;
                        ev        = bgc_pkg::EV_LL;
                    end
                end else begin
                    nxt.count = '0;
                    nxt.state = bgc_pkg::ST_LONG_RELEASE;
                    ev        = bgc_pkg::EV_LONG_REL;
                end
            end
            bgc_pkg::ST_SHORT_LONG_PRESS: begin
                if (!pressed) begin
                    nxt.count = '0;
                    nxt.state = bgc_pkg::ST_SHORT_LONG_RELEASE;
                    ev        = bgc_pkg::EV_SHORT_LONG_REL;
                end
            end
            bgc_pkg::ST_LL_PRESS: begin
                if (!pressed) begin
                    nxt.count = '0;
                    nxt.state = bgc_pkg::ST_LL_RELEASE;
                    ev        = bgc_pkg::EV_LL_REL;
                end
            end
            // The remaining release states and unused codes go back to idle quietly.
            default: begin
                nxt = bgc_pkg::ENTRY_RESET;
            end
        endcase
    end

endmodule

// ----- rtl/button_gesture_classifier_core.sv -----
// Button gesture classifier.
// Input stream: one transaction per scan tick of one button, carrying the button
// index and its raw active-low pin level. Output stream: one transaction per
// input transaction, in the same order, carrying the button index and an event
// code (none, single, double, long, long release, short-long, short-long
// release, long-long, long-long release).
// Thresholds are set through the write port (enable, index, data) while the
// block is idle; they take effect for the next transaction.
// Per-button gesture state and tick counter live in one memory with a registered
// read. A transaction reads its entry on acceptance, is classified in the next
// cycle and writes the entry back as it moves to the output register; a read
// that meets a write to the same entry takes the written value.
// Throughput: one transaction per cycle while the receiver does not stall. The
// result passes the classification stage register and then the output register.
// Reset clears the pipeline, returns the thresholds to their defaults and marks
// every memory entry as idle with a zero counter.
// When the receiver stalls, the result holds in the output register, the
// classification stage holds behind it and the input side stops accepting.
module button_gesture_classifier_core #(
    parameter int BUTTON_COUNT = bgc_pkg::BUTTON_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel. tdata: [2:0] button_index, [3] pin_level, [7:4] zero.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Output channel. tdata: [2:0] event_button, [6:3] event_code, [7] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    // Threshold write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data
);

    localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int EXT_W = IDX_W + 4;

    bgc_pkg::thresholds_t thr_reg;

    logic                 s_accept;
    logic [EXT_W-1:0]     in_idx_ext;
    logic [IDX_W-1:0]     in_addr;
    logic                 in_range;

    logic                 s1_valid_reg;
    logic [2:0]           s1_button_reg;
    logic [IDX_W-1:0]     s1_addr_reg;
    logic                 s1_pressed_reg;
    logic                 s1_inrange_reg;
    logic                 s1_adv;

    bgc_pkg::btn_entry_t  cur_entry;
    bgc_pkg::btn_entry_t  nxt_entry;
    bgc_pkg::event_code_t step_ev;
    bgc_pkg::event_code_t s1_ev;
    logic                 wr_en;

    logic                 m_tvalid_reg;
    logic [2:0]           m_button_reg;
    bgc_pkg::event_code_t m_code_reg;

    // Threshold registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= bgc_pkg::THR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                bgc_pkg::CFG_DEBOUNCE:        thr_reg.debounce        <= cfg_wr_data;
                bgc_pkg::CFG_LONG_PRESS:      thr_reg.long_press      <= cfg_wr_data;
                bgc_pkg::CFG_LONG_LONG_PRESS: thr_reg.long_long_press <= cfg_wr_data;
                bgc_pkg::CFG_DCLICK_GAP:      thr_reg.dclick_gap      <= cfg_wr_data;
            endcase
        end
    end

    // Handshake: the classification stage moves on when the output register frees up.
    assign s1_adv   = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    // Memory address and range check of the incoming button index.
    assign in_idx_ext = EXT_W'(s_tdata[2:0]);
    assign in_addr    = in_idx_ext[IDX_W-1:0];
    assign in_range   = (in_idx_ext < EXT_W'(BUTTON_COUNT));

    // Classification stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_button_reg  <= s_tdata[2:0];
            s1_addr_reg    <= in_addr;
            s1_pressed_reg <= !s_tdata[3];
            s1_inrange_reg <= in_range;
        end
    end

    // Per-button state memory.
    bgc_state_mem #(
        .DEPTH  (BUTTON_COUNT),
        .ADDR_W (IDX_W)
    ) u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (in_addr),
        .rd_data (cur_entry),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (nxt_entry)
    );

    // Gesture classification for the entry just read.
    bgc_gesture_step u_step (
        .cur     (cur_entry),
        .pressed (s1_pressed_reg),
        .thr     (thr_reg),
        .nxt     (nxt_entry),
        .ev      (step_ev)
    );

    // Buttons beyond the memory change nothing and report no event.
    assign wr_en = s1_adv && s1_inrange_reg;
    assign s1_ev = s1_inrange_reg ? step_ev : bgc_pkg::EV_NONE;

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_button_reg <= s1_button_reg;
            m_code_reg   <= s1_ev;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_code_reg, m_button_reg};

`ifndef SYNTHESIS
    // Every event is raised by a transition that clears the counter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && (step_ev != bgc_pkg::EV_NONE)) |-> (nxt_entry.count == '0))
        else $error("event raised without clearing the tick counter");

    // An out-of-range button reaches the output with no event.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && !s1_inrange_reg) |=> (m_code_reg == bgc_pkg::EV_NONE))
        else $error("out-of-range button produced an event");

    // A transaction leaving the classification stage lands in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> (m_tvalid_reg && (m_button_reg == $past(s1_button_reg))))
        else $error("classified transaction lost on its way to the output");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid_reg)
        else $error("output valid after reset");
`endif

endmodule

// ----- sim/bgc_gesture_checker.sv -----
module bgc_gesture_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,
    output int          mismatch_count,
    output int          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BUTTONS = bgc_pkg::BUTTON_COUNT_DEF;

    // What one scan tick is expected to report.
    typedef struct {
        logic [2:0]           button;
        bgc_pkg::event_code_t code;
    } tick_report_t;

    tick_report_t            expected_reports[$];
    bgc_pkg::gesture_state_t btn_state [NUM_BUTTONS];
    logic [15:0]             btn_count [NUM_BUTTONS];
    logic [15:0]             deb_thr;
    logic [15:0]             long_thr;
    logic [15:0]             ll_thr;
    logic [15:0]             gap_thr;
    int                      fail_tally = 0;

    assign mismatch_count = fail_tally;

    // Difference between two thresholds, never below zero.
    function automatic logic [15:0] stage_span(input logic [15:0] upper,
                                               input logic [15:0] lower);
        return (upper > lower) ? upper - lower : 16'd0;
    endfunction

    // Count one more tick; on reaching the limit clear the counter and say so.
    function automatic bit advance_count(input int unsigned btn, input logic [15:0] limit);
        logic [16:0] next_count;
        next_count = {1'b0, btn_count[btn]} + 17'd1;
        if (next_count >= {1'b0, limit}) begin
            btn_count[btn] = '0;
            return 1'b1;
        end
        btn_count[btn] = next_count[15:0];
        return 1'b0;
    endfunction

    function automatic void enter_state(input int unsigned btn,
                                        input bgc_pkg::gesture_state_t st);
        btn_count[btn] = '0;
        btn_state[btn] = st;
    endfunction

    // Advance one button by one scan tick and return the event it fires.
    function automatic bgc_pkg::event_code_t classify_tick(input int unsigned btn,
                                                           input logic pressed);
        bgc_pkg::event_code_t ev;
        ev = bgc_pkg::EV_NONE;
        case (btn_state[btn])
            bgc_pkg::ST_IDLE: begin
                enter_state(btn, pressed ? bgc_pkg::ST_FIRST_PRESS : bgc_pkg::ST_IDLE);
            end
            bgc_pkg::ST_FIRST_PRESS: begin
                if (!pressed) enter_state(btn, bgc_pkg::ST_IDLE);
                else if (advance_count(btn, deb_thr)) btn_state[btn] = bgc_pkg::ST_FIRST_VALID;
            end
            bgc_pkg::ST_FIRST_VALID: begin
                if (!pressed) begin
                    enter_state(btn, bgc_pkg::ST_FIRST_RELEASE);
                end else if (advance_count(btn, stage_span(long_thr, deb_thr))) begin
                    btn_state[btn] = bgc_pkg::ST_LONG_PRESS;
                    ev = bgc_pkg::EV_LONG;
                end
            end
            bgc_pkg::ST_FIRST_RELEASE: begin
                // A second press counts only inside the window [debounce, gap).
                if (!pressed) begin
                    if (advance_count(btn, gap_thr)) begin
                        btn_state[btn] = bgc_pkg::ST_IDLE;
                        ev = bgc_pkg::EV_SINGLE;
                    end
                end else if (btn_count[btn] >= deb_thr && btn_count[btn] < gap_thr) begin
                    enter_state(btn, bgc_pkg::ST_SECOND_PRESS);
                end else if (btn_count[btn] < deb_thr) begin
                    enter_state(btn, bgc_pkg::ST_IDLE);
                    ev = bgc_pkg::EV_SINGLE;
                end
            end
            bgc_pkg::ST_SECOND_PRESS: begin
                if (!pressed) begin
                    enter_state(btn, bgc_pkg::ST_IDLE);
                    ev = bgc_pkg::EV_SINGLE;
                end else if (advance_count(btn, deb_thr)) begin
                    btn_state[btn] = bgc_pkg::ST_SECOND_VALID;
                end
            end
            bgc_pkg::ST_SECOND_VALID: begin
                if (!pressed) begin
                    enter_state(btn, bgc_pkg::ST_IDLE);
                    ev = bgc_pkg::EV_DOUBLE;
                end else if (advance_count(btn, stage_span(long_thr, deb_thr))) begin
                    btn_state[btn] = bgc_pkg::ST_SHORT_LONG_PRESS;
                    ev = bgc_pkg::EV_SHORT_LONG;
                end
            end
            bgc_pkg::ST_LONG_PRESS: begin
                if (!pressed) begin
                    enter_state(btn, bgc_pkg::ST_LONG_RELEASE);
                    ev = bgc_pkg::EV_LONG_REL;
                end else if (advance_count(btn, stage_span(ll_thr, long_thr))) begin
                    btn_state[btn] = bgc_pkg::ST_LL_PRESS;
                    ev = bgc_pkg::EV_LL;
                end
            end
            bgc_pkg::ST_SHORT_LONG_PRESS: begin
                if (!pressed) begin
                    enter_state(btn, bgc_pkg::ST_SHORT_LONG_RELEASE);
                    ev = bgc_pkg::EV_SHORT_LONG_REL;
                end
            end
            bgc_pkg::ST_LL_PRESS: begin
                if (!pressed) begin
                    enter_state(btn, bgc_pkg::ST_LL_RELEASE);
                    ev = bgc_pkg::EV_LL_REL;
                end
            end
            // The remaining release states fall back to idle on the next tick.
            default: begin
                enter_state(btn, bgc_pkg::ST_IDLE);
            end
        endcase
        return ev;
    endfunction

    // Watch the write port and both channels on every rising edge.
    always @(posedge aclk) begin
        tick_report_t want;
        if (!aresetn) begin
            deb_thr  = 16'd2;
            long_thr = 16'd100;
            ll_thr   = 16'd300;
            gap_thr  = 16'd30;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                btn_state[i] = bgc_pkg::ST_IDLE;
                btn_count[i] = '0;
            end
            expected_reports.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    bgc_pkg::CFG_DEBOUNCE:        deb_thr  = cfg_wr_data;
                    bgc_pkg::CFG_LONG_PRESS:      long_thr = cfg_wr_data;
                    bgc_pkg::CFG_LONG_LONG_PRESS: ll_thr   = cfg_wr_data;
                    bgc_pkg::CFG_DCLICK_GAP:      gap_thr  = cfg_wr_data;
                    default: ;
                endcase
            end

            // Predict the report for each accepted input transaction.
            if (s_tvalid && s_tready) begin
                expected_reports.push_back('{
                    button: s_tdata[2:0],
                    code:   classify_tick(s_tdata[2:0], !s_tdata[3])
                });
            end

            // Compare each output transaction with the oldest prediction.
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected output transaction: tdata %h", m_tdata);
                    fail_tally++;
                end else begin
                    want = expected_reports.pop_front();
                    if (m_tdata[2:0] !== want.button) begin
                        $error("event_button: expected %0d, got %0d", want.button, m_tdata[2:0]);
                        fail_tally++;
                    end
                    if (m_tdata[6:3] !== want.code) begin
                        $error("event_code: expected %0d, got %0d", want.code, m_tdata[6:3]);
                        fail_tally++;
                    end
                end
            end
        end
        pending_results <= expected_reports.size();
    end

endmodule

// ----- sim/button_gesture_classifier_core_test.sv -----
module button_gesture_classifier_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic PIN_PRESSED  = 1'b0;
    localparam logic PIN_RELEASED = 1'b1;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wr_data;
    int          mismatch_count;
    int          pending_results;

    // Traffic shaping for the current phase.
    int gap_pct   = 0;
    int stall_pct = 0;
    int noise_pct = 0;
    int ticks_sent = 0;

    // Thresholds currently programmed, used to size the gestures.
    int cur_deb = 2;
    int cur_lp  = 100;
    int cur_llp = 300;
    int cur_gap = 30;

    button_gesture_classifier_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    bgc_gesture_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Keep gesture lengths bounded when thresholds are huge.
    function automatic int capped(input int v);
        return (v > 40) ? 40 : v;
    endfunction

    // Offer one scan tick, with an optional idle gap in front of it.
    task automatic send_tick(input logic [2:0] btn, input logic pin);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, pin, btn};
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
    endtask

    // A run of identical pin levels on one button, sometimes interleaved with stray ticks.
    task automatic hold_run(input logic [2:0] btn, input logic pin, input int len);
        repeat (len) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_tick(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            send_tick(btn, pin);
        end
    endtask

    // Stop offering and wait until every predicted report has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_thresholds(input int deb, input int lp, input int llp, input int gap);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= bgc_pkg::CFG_DEBOUNCE;
        cfg_wr_data <= deb[15:0];
        @(posedge aclk);
        cfg_addr    <= bgc_pkg::CFG_LONG_PRESS;
        cfg_wr_data <= lp[15:0];
        @(posedge aclk);
        cfg_addr    <= bgc_pkg::CFG_LONG_LONG_PRESS;
        cfg_wr_data <= llp[15:0];
        @(posedge aclk);
        cfg_addr    <= bgc_pkg::CFG_DCLICK_GAP;
        cfg_wr_data <= gap[15:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_deb = deb;
        cur_lp  = lp;
        cur_llp = llp;
        cur_gap = gap;
    endtask

    // One click-like gesture with random timing, or a burst of random ticks.
    task automatic play_gesture();
        logic [2:0] btn;
        int kind;
        int hold;
        btn  = 3'($urandom_range(0, 7));
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            repeat ($urandom_range(1, 4))
                send_tick(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end else begin
            repeat ((kind < 6) ? 1 : 2) begin
                case ($urandom_range(0, 2))
                    0:       hold = $urandom_range(1, capped(cur_deb) + 1);
                    1:       hold = $urandom_range(1, capped(cur_lp) + 2);
                    default: hold = $urandom_range(1, capped(cur_llp) + 3);
                endcase
                hold_run(btn, PIN_PRESSED, hold);
                hold_run(btn, PIN_RELEASED, $urandom_range(1, capped(cur_gap) + 2));
            end
        end
    endtask

    task automatic run_phase(input int deb, input int lp, input int llp, input int gap,
                             input int gpct, input int spct, input int count);
        int target;
        write_thresholds(deb, lp, llp, gap);
        gap_pct   = gpct;
        stall_pct = spct;
        noise_pct = 10;
        target    = ticks_sent + count;
        while (ticks_sent < target) play_gesture();
        settle();
    endtask

    initial begin
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= bgc_pkg::CFG_DEBOUNCE;
        cfg_wr_data <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset thresholds: a press too short to pass the default debounce.
        hold_run(3'd4, PIN_PRESSED, 2);
        hold_run(3'd4, PIN_RELEASED, 1);
        settle();

        // Directed gestures with tiny thresholds.
        write_thresholds(1, 3, 5, 3);
        // Long press running on into long-long, then its release.
        hold_run(3'd0, PIN_PRESSED, 7);
        hold_run(3'd0, PIN_RELEASED, 2);
        // Double click on the highest button.
        hold_run(3'd7, PIN_PRESSED, 2);
        hold_run(3'd7, PIN_RELEASED, 2);
        hold_run(3'd7, PIN_PRESSED, 3);
        hold_run(3'd7, PIN_RELEASED, 1);
        // Second press arriving before the debounce time after the first release.
        hold_run(3'd3, PIN_PRESSED, 2);
        hold_run(3'd3, PIN_RELEASED, 1);
        hold_run(3'd3, PIN_PRESSED, 1);
        settle();

        // Gap shortened under a button already waiting in its first release.
        write_thresholds(1, 3, 5, 20);
        hold_run(3'd2, PIN_PRESSED, 2);
        hold_run(3'd2, PIN_RELEASED, 6);
        settle();
        write_thresholds(1, 3, 5, 3);
        hold_run(3'd2, PIN_PRESSED, 1);
        hold_run(3'd2, PIN_RELEASED, 1);
        settle();

        // Random gestures over several threshold settings and traffic patterns.
        run_phase(2, 6, 10, 4, 0, 0, 70);
        run_phase(1, 2, 3, 1, 74, 0, 70);
        run_phase(3, 8, 14, 6, 0, 74, 70);
        // All thresholds zero: every stage passes on its first tick.
        run_phase(0, 0, 0, 0, 13, 13, 60);
        // Thresholds out of order.
        run_phase(6, 3, 2, 2, 0, 0, 60);
        run_phase(65535, 65535, 65535, 65535, 13, 13, 30);
        begin
            int deb;
            int lp;
            deb = $urandom_range(1, 4);
            lp  = deb + $urandom_range(1, 5);
            run_phase(deb, lp, lp + $urandom_range(1, 6), $urandom_range(1, 8), 0, 0, 70);
        end

        if (mismatch_count == 0 && pending_results == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bgc_pkg.sv
rtl/bgc_state_mem.sv
rtl/bgc_gesture_step.sv
rtl/button_gesture_classifier_core.sv
sim/bgc_gesture_checker.sv
sim/button_gesture_classifier_core_test.sv
